// ===== src/fasub_pkg.sv =====
//------------------------------------------------------------------------------
// fasub_pkg
// Shared constants and types for the truncating single-precision adder.
//------------------------------------------------------------------------------
package fasub_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned EXP_W    = 8;
    localparam int unsigned MANT_W   = 23;
    localparam int unsigned SIG_W    = 25;
    localparam logic [4:0]  MAX_ALIGN = 5'd23;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } t_op;

endpackage

// ===== src/fasub_datapath.sv =====
//------------------------------------------------------------------------------
// fasub_datapath
// Combinational add/subtract: select, align, add, normalize, pack.
//------------------------------------------------------------------------------
module fasub_datapath (
    input  logic              i_op,
    input  fasub_pkg::t_word  i_a,
    input  fasub_pkg::t_word  i_b,
    output fasub_pkg::t_word  o_sum
);
    import fasub_pkg::*;

    t_word       b_eff;
    logic [7:0]  ea, eb, big_e, diff;
    logic [22:0] ma, mb;
    logic        sa, sb, big_s, a_big;
    logic [23:0] big_m, small_m, small_sh;
    logic [24:0] sum;
    logic [4:0]  lz;
    logic        found;
    logic [24:0] norm;
    logic [8:0]  e_dec;
    t_word       packed_w;

    always_comb begin
        b_eff = i_b;
        if (t_op'(i_op) == OP_SUB) begin
            b_eff[31] = ~i_b[31];
        end
        ea = i_a[30:23];
        eb = b_eff[30:23];
        ma = i_a[22:0];
        mb = b_eff[22:0];
        sa = i_a[31];
        sb = b_eff[31];
        a_big = (ea > eb) || ((ea == eb) && (ma > mb));
        if (a_big) begin
            big_s = sa; big_e = ea; big_m = {1'b1, ma}; small_m = {1'b1, mb};
            diff = ea - eb;
        end else begin
            big_s = sb; big_e = eb; big_m = {1'b1, mb}; small_m = {1'b1, ma};
            diff = eb - ea;
        end
        small_sh = (diff > {3'd0, MAX_ALIGN}) ? '0 : (small_m >> diff[4:0]);
        sum = (sa == sb) ? ({1'b0, big_m} + {1'b0, small_sh})
                         : ({1'b0, big_m} - {1'b0, small_sh});
        lz = '0;
        found = 1'b0;
        for (int k = 0; k < SIG_W; k++) begin
            if (!found && sum[SIG_W-1-k]) begin
                found = 1'b1;
                lz = 5'(k);
            end
        end
        norm = '0;
        e_dec = '0;
        packed_w = '0;
        if (!found) begin
            packed_w = '0;
        end else if (lz == 5'd0) begin
            packed_w = {big_s, 31'd0} + {1'b0, 8'(big_e + 8'd1), 23'd0}
                     + {9'd0, sum[23:1]};
            if (big_e == 8'hff) begin
                packed_w = {~big_s, 8'd0, sum[23:1]};
            end
        end else begin
            e_dec = {1'b0, big_e} - {4'd0, (lz - 5'd1)};
            norm  = sum << (lz - 5'd1);
            if (e_dec[8]) begin
                packed_w = '0;
            end else begin
                packed_w = {big_s, e_dec[7:0], norm[22:0]};
            end
        end
        if (ea == '0) begin
            o_sum = b_eff;
        end else if (eb == '0) begin
            o_sum = i_a;
        end else begin
            o_sum = packed_w;
        end
    end

endmodule

// ===== src/float32_add_sub_truncating_core.sv =====
//------------------------------------------------------------------------------
// float32_add_sub_truncating_core
// Truncating single-precision adder/subtractor with input and result registers.
//
//  channel | signals                                | dir
//  in      | i_valid, o_ready, i_operation, i_a/b_bits | in
//  out     | o_valid, i_ready, o_sum_bits           | out
//
// One item per cycle while the result side takes results; accepted operands go to the
// input register, and their sum then goes to the result register when it can advance.
// The path from input register to result register is one single pass.
// Reset (synchronous, active low) clears the valid flags only.
// A stalled result holds; the input stage still fills while the result is taken.
//------------------------------------------------------------------------------
module float32_add_sub_truncating_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_operation,
    input  fasub_pkg::t_word  i_a_bits,
    input  fasub_pkg::t_word  i_b_bits,
    output logic              o_valid,
    input  logic              i_ready,
    output fasub_pkg::t_word  o_sum_bits
);
    import fasub_pkg::*;

    logic  r_in_v, r_out_v, n_in_v, n_out_v;
    logic  r_op;
    t_word r_a, r_b, r_sum, w_sum;
    logic  adv;

    assign adv     = !r_out_v || i_ready;
    assign o_ready = !r_in_v || adv;
    assign o_valid = r_out_v;
    assign o_sum_bits = r_sum;

    fasub_datapath u_dp (
        .i_op  (r_op),
        .i_a   (r_a),
        .i_b   (r_b),
        .o_sum (w_sum)
    );

    always_comb begin
        n_out_v = adv ? r_in_v : r_out_v;
        n_in_v  = (i_valid && o_ready) ? 1'b1 : (adv ? 1'b0 : r_in_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= n_in_v;
            r_out_v <= n_out_v;
        end
        if (i_valid && o_ready) begin
            r_op <= i_operation;
            r_a  <= i_a_bits;
            r_b  <= i_b_bits;
        end
        if (adv && r_in_v) begin
            r_sum <= w_sum;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |=> (r_out_v && $stable(r_sum)))
        else $error("result changed while stalled");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && adv) |=> r_out_v)
        else $error("item lost between stages");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_v) |-> o_ready)
        else $error("empty input stage not ready");

endmodule

// ===== tb/fasub_checker.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// fasub_checker
// Watches both channels of the adder, predicts each sum from the accepted
// operands and compares it with the sum that is taken from the block.
//------------------------------------------------------------------------------
module fasub_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_in_ready,
    input  logic              i_operation,
    input  fasub_pkg::t_word  i_a_bits,
    input  fasub_pkg::t_word  i_b_bits,
    input  logic              i_out_valid,
    input  logic              i_ready,
    input  fasub_pkg::t_word  i_sum_bits,
    output int                o_fail_count,
    output int                o_pending
);
    import fasub_pkg::*;

    t_word sum_queue[$];

    function automatic t_word trunc_add(t_op op, t_word a, t_word b_in);
        t_word       b;
        logic [7:0]  ea, eb, big_e;
        logic [22:0] ma, mb;
        logic        sa, sb, big_s;
        logic [31:0] big_m, small_m, dif, sum;
        int          k;
        b = b_in;
        if (op == OP_SUB) begin
            b[31] = ~b[31];
        end
        ea = a[30:23];
        eb = b[30:23];
        ma = a[22:0];
        mb = b[22:0];
        sa = a[31];
        sb = b[31];
        if (ea == 0) return b;
        if (eb == 0) return a;
        if (ea > eb || (ea == eb && ma > mb)) begin
            big_s = sa; big_e = ea; big_m = {9'd1, ma}; small_m = {9'd1, mb};
            dif = ea - eb;
        end else begin
            big_s = sb; big_e = eb; big_m = {9'd1, mb}; small_m = {9'd1, ma};
            dif = eb - ea;
        end
        small_m = (dif > 23) ? 32'd0 : (small_m >> dif);
        sum = (sa == sb) ? big_m + small_m : big_m - small_m;
        for (k = 0; k <= 24; k++) begin
            if (sum[24-k]) begin
                if (k == 0)
                    return (32'(big_s) << 31) + ((32'(big_e) + 1) << 23)
                           + ((sum >> 1) & 32'h7fffff);
                if (32'(big_e) < k - 1) return 32'd0;
                return (32'(big_s) << 31) + ((32'(big_e) - (k - 1)) << 23)
                       + ((sum << (k - 1)) & 32'h7fffff);
            end
        end
        return 32'd0;
    endfunction

    assign o_pending = sum_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && i_in_ready) begin
                sum_queue.push_back(trunc_add(t_op'(i_operation), i_a_bits, i_b_bits));
            end
            if (i_out_valid && i_ready) begin
                if (sum_queue.size() == 0) begin
                    $error("sum_bits: unexpected item, actual %h", i_sum_bits);
                    o_fail_count <= o_fail_count + 1;
                end else if (sum_queue[0] !== i_sum_bits) begin
                    $error("sum_bits: expected %h actual %h", sum_queue[0], i_sum_bits);
                    o_fail_count <= o_fail_count + 1;
                    void'(sum_queue.pop_front());
                end else begin
                    void'(sum_queue.pop_front());
                end
            end
        end
    end

endmodule

// ===== tb/tb_float32_add_sub_truncating_core.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_float32_add_sub_truncating_core
// Drives directed and random operand pairs through the truncating adder
// with varying stalls on both sides; the checker predicts and compares.
//------------------------------------------------------------------------------
module tb_float32_add_sub_truncating_core;
    import fasub_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    logic  i_operation = 1'b0;
    t_word i_a_bits = '0;
    t_word i_b_bits = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_word o_sum_bits;
    int    fail_count;
    int    pending;
    int    idle_send_pct = 0;
    int    idle_recv_pct = 0;
    int    quiet_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    float32_add_sub_truncating_core dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_operation, .i_a_bits, .i_b_bits,
        .o_valid, .i_ready, .o_sum_bits
    );

    fasub_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_operation,
        .i_a_bits, .i_b_bits, .i_out_valid(o_valid), .i_ready,
        .i_sum_bits(o_sum_bits), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= idle_recv_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_word rand_word();
        t_word w;
        w = $urandom;
        case ($urandom_range(5))
            0: w[30:23] = 8'd0;
            1: w[30:23] = 8'hff;
            2: w[30:23] = 8'($urandom_range(1, 3));
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_item(logic op, t_word a, t_word b);
        while ($urandom_range(99) < idle_send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_a_bits    <= a;
        i_b_bits    <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        t_word a, b;
        for (int n = 0; n < count; n++) begin
            a = rand_word();
            if ($urandom_range(2) == 0) begin
                b = a;
                b[31] = 1'($urandom);
                b[30:23] = 8'(a[30:23] + $urandom_range(0, 2) - 1);
                b[5:0] = 6'($urandom);
            end else if ($urandom_range(3) == 0) begin
                b = a;
                b[30:23] = 8'(a[30:23] - $urandom_range(20, 26));
            end else begin
                b = rand_word();
            end
            send_item(1'($urandom), a, b);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_send_pct = 38;
        idle_recv_pct = 50;
        send_item(OP_ADD, 32'h0000_1234, 32'h3f80_0000);
        send_item(OP_SUB, 32'h0000_0000, 32'h3f80_0000);
        send_item(OP_ADD, 32'h3f80_0000, 32'h8000_0005);
        send_item(OP_SUB, 32'h3f80_0000, 32'h3f80_0000);
        send_item(OP_ADD, 32'h3f80_0000, 32'hbf80_0000);
        send_item(OP_ADD, 32'h3fc0_0000, 32'h3fc0_0000);
        send_item(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(OP_ADD, 32'hffff_ffff, 32'hffff_ffff);
        send_item(OP_SUB, 32'h7f80_0000, 32'h7f00_0000);
        send_item(OP_ADD, 32'h3f80_0000, 32'h3380_0000);
        send_item(OP_ADD, 32'h3f80_0000, 32'h3300_0000);
        send_item(OP_ADD, 32'h3f80_0000, 32'h0080_0000);
        send_item(OP_SUB, 32'h0080_0001, 32'h0080_0000);
        send_item(OP_SUB, 32'h0100_0001, 32'h0100_0000);
        send_item(OP_SUB, 32'h00ff_ffff, 32'h00ff_fffe);
        send_item(OP_SUB, 32'h3f80_0001, 32'h3f80_0000);
        send_item(OP_ADD, 32'h3f80_0000, 32'hbf80_0001);
        send_item(OP_SUB, 32'h4000_0000, 32'h3fff_ffff);
        send_item(OP_ADD, 32'h8000_0000, 32'h0000_0000);
        send_random(180);
        drain();
        idle_send_pct = 50;
        idle_recv_pct = 38;
        send_random(200);
        idle_send_pct = 0;
        idle_recv_pct = 0;
        send_random(200);
        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
